>>> rtl/twdf_pkg.sv
// Package for the transfer window de-duplication filter.
// Holds the table geometry, register and status codes, and shared types.
// No dependencies.
package twdf_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 32;
    localparam int PAIR_W      = ADDR_W + LEN_W;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_FLOOR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_FLOOR = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE   = CFG_IDX_W'(3);

    localparam logic [ADDR_W-1:0] ADDR_FLOOR_RST = 32'h0008_0000;
    localparam logic [LEN_W-1:0]  SIZE_FLOOR_RST = 32'd4096;
    localparam logic [ADDR_W-1:0] MEM_SIZE_RST   = 32'd2097152;

    localparam logic [2:0] ST_NEW         = 3'd0;
    localparam logic [2:0] ST_DISABLED    = 3'd1;
    localparam logic [2:0] ST_BELOW_FLOOR = 3'd2;
    localparam logic [2:0] ST_TOO_SMALL   = 3'd3;
    localparam logic [2:0] ST_PAST_END    = 3'd4;
    localparam logic [2:0] ST_DUPLICATE   = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic              enable;
        logic [ADDR_W-1:0] addr_floor;
        logic [LEN_W-1:0]  size_floor;
        logic [ADDR_W-1:0] mem_size;
    } cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [PAIR_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

>>> rtl/transfer_window_dedup_filter.sv
// Top level of the transfer window de-duplication filter.
// Depends on twdf_pkg, twdf_cfg_regs, twdf_pair_ram and twdf_scan_ctrl.
//
//   Channel  Direction  Handshake              Payload
//   s_       in         s_valid / s_ready      s_start_addr[31:0], s_byte_count[31:0]
//   m_       out        m_valid / m_ready      m_logged, m_status[2:0], m_stored
//   cfg_     in         cfg_valid / cfg_ready  cfg_index[7:0], cfg_data[31:0]
//
// One transfer at a time: accept, a check state, then, when the checks pass and
// the table is not empty, a walk over the pair RAM (one read issued per cycle,
// compared in the cycle after), then a result state. The walk ends early on a
// duplicate. Reset clears the control registers and fill count only; the RAM
// needs no clearing pass. A new transfer is taken while a result waits; a held
// result stalls the next one only in its result state.
module transfer_window_dedup_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [twdf_pkg::ADDR_W-1:0]     s_start_addr,
    input  logic [twdf_pkg::LEN_W-1:0]      s_byte_count,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_logged,
    output logic [2:0]                     m_status,
    output logic                           m_stored,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [twdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [twdf_pkg::CFG_DATA_W-1:0] cfg_data
);

    twdf_pkg::cfg_t              cfg;
    twdf_pkg::ram_req_t          ram_req;
    logic [twdf_pkg::PAIR_W-1:0] ram_rd_data;

    twdf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    twdf_pair_ram u_pair_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    twdf_scan_ctrl u_scan_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_addr (s_start_addr),
        .s_byte_count (s_byte_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_logged     (m_logged),
        .m_status     (m_status),
        .m_stored     (m_stored),
        .ram_req      (ram_req),
        .ram_rd_data  (ram_rd_data)
    );

endmodule

>>> rtl/twdf_pair_ram.sv
// Seen-pair table: one write port, one read port, registered read data.
// Depends on twdf_pkg for depth and widths.
module twdf_pair_ram (
    input  logic                      aclk,
    input  twdf_pkg::ram_req_t        req,
    output logic [twdf_pkg::PAIR_W-1:0] rd_data
);

    logic [twdf_pkg::PAIR_W-1:0] mem [twdf_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

>>> rtl/twdf_cfg_regs.sv
// Configuration register file for the filter, written over its own channel.
// Depends on twdf_pkg for register codes, reset values and cfg_t.
module twdf_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [twdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [twdf_pkg::CFG_DATA_W-1:0] cfg_data,
    output twdf_pkg::cfg_t                 cfg
);

    twdf_pkg::cfg_t cfg_reg;
    twdf_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                twdf_pkg::REG_ENABLE:     cfg_next.enable     = cfg_data[0];
                twdf_pkg::REG_ADDR_FLOOR: cfg_next.addr_floor = cfg_data;
                twdf_pkg::REG_SIZE_FLOOR: cfg_next.size_floor = cfg_data;
                twdf_pkg::REG_MEM_SIZE:   cfg_next.mem_size   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.addr_floor <= twdf_pkg::ADDR_FLOOR_RST;
            cfg_reg.size_floor <= twdf_pkg::SIZE_FLOOR_RST;
            cfg_reg.mem_size   <= twdf_pkg::MEM_SIZE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/twdf_scan_ctrl.sv
// Sequencer: window checks, table walk through the pair RAM, append and result register.
// Depends on twdf_pkg for state, status codes, cfg_t and ram_req_t.
module twdf_scan_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  twdf_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [twdf_pkg::ADDR_W-1:0]    s_start_addr,
    input  logic [twdf_pkg::LEN_W-1:0]     s_byte_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_logged,
    output logic [2:0]                    m_status,
    output logic                          m_stored,
    output twdf_pkg::ram_req_t            ram_req,
    input  logic [twdf_pkg::PAIR_W-1:0]    ram_rd_data
);

    twdf_pkg::state_t state_reg, state_next;

    logic [twdf_pkg::ADDR_W-1:0] addr_reg;
    logic [twdf_pkg::LEN_W-1:0]  len_reg;
    logic [twdf_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic [twdf_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [2:0]                  status_reg, status_next;

    logic                        m_valid_reg, m_valid_next;
    logic                        m_logged_reg;
    logic [2:0]                  m_status_reg;
    logic                        m_stored_reg;

    logic [twdf_pkg::ADDR_W:0]   end_addr;
    logic [2:0]                  check_status;
    logic                        check_pass;
    logic                        issue;
    logic                        match;
    logic                        out_free;
    logic                        is_new;
    logic                        has_room;

    // End is formed one bit wider so a wrapping transfer is still seen as past the end.
    assign end_addr = {1'b0, addr_reg} + {1'b0, len_reg};

    always_comb begin
        if (!cfg.enable) begin
            check_status = twdf_pkg::ST_DISABLED;
        end else if (addr_reg < cfg.addr_floor) begin
            check_status = twdf_pkg::ST_BELOW_FLOOR;
        end else if (len_reg < cfg.size_floor) begin
            check_status = twdf_pkg::ST_TOO_SMALL;
        end else if (end_addr > {1'b0, cfg.mem_size}) begin
            check_status = twdf_pkg::ST_PAST_END;
        end else begin
            check_status = twdf_pkg::ST_NEW;
        end
    end

    assign check_pass = (check_status == twdf_pkg::ST_NEW);
    assign issue      = (state_reg == twdf_pkg::S_SCAN) && (idx_reg < fill_reg);
    assign match      = cmp_valid_reg && (ram_rd_data == {addr_reg, len_reg});
    assign out_free   = !m_valid_reg || m_ready;
    assign is_new     = (status_reg == twdf_pkg::ST_NEW);
    assign has_room   = (fill_reg < twdf_pkg::DEPTH_CNT);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            twdf_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = twdf_pkg::S_CHECK;
                end
            end
            twdf_pkg::S_CHECK: begin
                if (check_pass && (fill_reg != '0)) begin
                    state_next = twdf_pkg::S_SCAN;
                end else begin
                    state_next = twdf_pkg::S_RESULT;
                end
            end
            twdf_pkg::S_SCAN: begin
                // The compare of the last entry lands in the cycle after its read is issued.
                if (match || (cmp_valid_reg && !issue)) begin
                    state_next = twdf_pkg::S_RESULT;
                end
            end
            twdf_pkg::S_RESULT: begin
                if (out_free) begin
                    state_next = twdf_pkg::S_IDLE;
                end
            end
            default: state_next = twdf_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath next values.
    always_comb begin
        s_ready         = 1'b0;
        idx_next        = idx_reg;
        cmp_valid_next  = 1'b0;
        status_next     = status_reg;
        fill_next       = fill_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = fill_reg[twdf_pkg::IDX_W-1:0];
        ram_req.wr_data = {addr_reg, len_reg};
        ram_req.rd_en   = issue;
        ram_req.rd_addr = idx_reg[twdf_pkg::IDX_W-1:0];
        case (state_reg)
            twdf_pkg::S_IDLE: begin
                s_ready = 1'b1;
            end
            twdf_pkg::S_CHECK: begin
                status_next = check_status;
                idx_next    = '0;
            end
            twdf_pkg::S_SCAN: begin
                cmp_valid_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (match) begin
                    status_next = twdf_pkg::ST_DUPLICATE;
                end
            end
            twdf_pkg::S_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (is_new && has_room) begin
                        ram_req.wr_en = 1'b1;
                        fill_next     = fill_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= twdf_pkg::S_IDLE;
            fill_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            addr_reg <= s_start_addr;
            len_reg  <= s_byte_count;
        end
        idx_reg    <= idx_next;
        status_reg <= status_next;
        if ((state_reg == twdf_pkg::S_RESULT) && out_free) begin
            m_status_reg <= status_reg;
            m_logged_reg <= is_new;
            m_stored_reg <= is_new && has_room;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_logged = m_logged_reg;
    assign m_status = m_status_reg;
    assign m_stored = m_stored_reg;

endmodule

>>> dv/transfer_window_dedup_filter_test.sv
// Self-checking testbench for transfer_window_dedup_filter.
// Depends on twdf_pkg and the RTL of the filter. It predicts each verdict and
// checks every result transfer in order, under random idling on both sides.
module transfer_window_dedup_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import twdf_pkg::*;

    // Software copy of the filter: registers, seen-pair table and the verdicts
    // still owed by the block, oldest first.
    class dedup_tracker;
        typedef struct packed {
            logic       logged;
            logic [2:0] status;
            logic       stored;
        } verdict_t;

        logic              enable;
        logic [ADDR_W-1:0] addr_floor;
        logic [LEN_W-1:0]  size_floor;
        logic [ADDR_W-1:0] mem_size;
        logic [ADDR_W-1:0] seen_addr [TABLE_DEPTH];
        logic [LEN_W-1:0]  seen_len  [TABLE_DEPTH];
        int                fill;
        verdict_t          pending_verdicts [$];
        int                mismatches;

        function new();
            enable     = 1'b0;
            addr_floor = ADDR_FLOOR_RST;
            size_floor = SIZE_FLOOR_RST;
            mem_size   = MEM_SIZE_RST;
            fill       = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLE:     enable = data[0];
                REG_ADDR_FLOOR: addr_floor = data;
                REG_SIZE_FLOOR: size_floor = data;
                REG_MEM_SIZE:   mem_size = data;
                default: ;
            endcase
        endfunction

        function void note_transfer(logic [ADDR_W-1:0] a, logic [LEN_W-1:0] n);
            logic [ADDR_W:0] last_byte;
            verdict_t        v;
            bit              known;
            int              i;
            // The end is formed one bit wider so that it cannot wrap around.
            last_byte = {1'b0, a} + {1'b0, n};
            v = '0;
            known = 1'b0;
            if (!enable) begin
                v.status = ST_DISABLED;
            end else if (a < addr_floor) begin
                v.status = ST_BELOW_FLOOR;
            end else if (n < size_floor) begin
                v.status = ST_TOO_SMALL;
            end else if (last_byte > {1'b0, mem_size}) begin
                v.status = ST_PAST_END;
            end else begin
                for (i = 0; i < fill; i++) begin
                    if (seen_addr[i] == a && seen_len[i] == n) begin
                        known = 1'b1;
                    end
                end
                if (known) begin
                    v.status = ST_DUPLICATE;
                end else begin
                    v.status = ST_NEW;
                    v.logged = 1'b1;
                    // A full table still reports the pair but keeps it out.
                    if (fill < TABLE_DEPTH) begin
                        seen_addr[fill] = a;
                        seen_len[fill]  = n;
                        fill++;
                        v.stored = 1'b1;
                    end
                end
            end
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(logic logged, logic [2:0] status, logic stored);
            verdict_t v;
            if (pending_verdicts.size() == 0) begin
                $error("result with no transfer outstanding: logged %0d status %0d stored %0d",
                       logged, status, stored);
                mismatches++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (logged !== v.logged) begin
                $error("logged: expected %0d, actual %0d", v.logged, logged);
                mismatches++;
            end
            if (status !== v.status) begin
                $error("status: expected %0d, actual %0d", v.status, status);
                mismatches++;
            end
            if (stored !== v.stored) begin
                $error("stored: expected %0d, actual %0d", v.stored, stored);
                mismatches++;
            end
        endfunction
    endclass

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } xfer_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_start_addr = '0;
    logic [LEN_W-1:0]      s_byte_count = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_logged;
    logic [2:0]            m_status;
    logic                  m_stored;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    dedup_tracker sb = new();
    xfer_t        history [$];
    bit           idle_on = 1'b1;
    int           sink_hold = 0;

    transfer_window_dedup_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_addr (s_start_addr),
        .s_byte_count (s_byte_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_logged     (m_logged),
        .m_status     (m_status),
        .m_stored     (m_stored),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("transfer_window_dedup_filter verification failed");
        $finish;
    end

    // Result side: checks each accepted result and decides m_ready for the
    // next cycle, including the long hold that backs the block up.
    initial begin : result_sink
        int burst;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_logged, m_status, m_stored);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(8, 0);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_transfer(input logic [ADDR_W-1:0] a, input logic [LEN_W-1:0] n);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_start_addr <= a;
        s_byte_count <= n;
        do @(posedge aclk); while (!s_ready);
        sb.note_transfer(a, n);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_verdicts.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Writes all four registers in a rotated order, sometimes with a stray
    // write to an unused index mixed in.
    task automatic program_regs(input logic [31:0] en, input logic [31:0] af,
                                input logic [31:0] sf, input logic [31:0] ms);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idx;
        int                    first;
        int                    k;
        wait_idle();
        vals[REG_ENABLE]     = en;
        vals[REG_ADDR_FLOOR] = af;
        vals[REG_SIZE_FLOOR] = sf;
        vals[REG_MEM_SIZE]   = ms;
        first = $urandom_range(3, 0);
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(255, REG_MEM_SIZE + 1)), $urandom);
        end
        for (k = 0; k < 4; k++) begin
            idx = CFG_IDX_W'((first + k) % 4);
            write_reg(idx, vals[idx]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] span_pick(longint span);
        // The ends of the span sit right on the accept and reject boundaries.
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return span[31:0];
            default: return $urandom_range(span[31:0], 0);
        endcase
    endfunction

    function automatic bit window_xfer(output xfer_t x);
        longint af;
        longint sf;
        longint ms;
        longint slack;
        af = sb.addr_floor;
        sf = sb.size_floor;
        ms = sb.mem_size;
        slack = ms - af - sf;
        x = '0;
        if (!sb.enable || slack < 0) begin
            return 1'b0;
        end
        x.addr = 32'(af + span_pick(slack));
        x.len  = 32'(sf + span_pick(ms - longint'(x.addr) - sf));
        return 1'b1;
    endfunction

    // Mostly well-formed transfers, a quarter replays of earlier ones, and the
    // rest nudged across one boundary or raw random bits.
    function automatic xfer_t next_item();
        xfer_t x;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < 25 && history.size() > 0) begin
            return history[$urandom_range(history.size() - 1, 0)];
        end
        if (roll < 80 && window_xfer(x)) begin
            history.push_back(x);
            return x;
        end
        if (window_xfer(x)) begin
            case ($urandom_range(0, 4))
                0: x.addr = x.addr - 1;
                1: x.len = x.len - 1;
                2: x.len = x.len + 1;
                3: x.addr = x.addr + 1;
                default: x = {$urandom, $urandom};
            endcase
        end else begin
            x = {$urandom, $urandom};
        end
        return x;
    endfunction

    task automatic run_phase(input int p);
        logic [31:0] af;
        int          count;
        xfer_t       x;
        af = $urandom;
        count = 260;
        case (p)
            0: program_regs(32'd1, 32'h1000, 32'h10, 32'h1100);
            1: begin
                program_regs(32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF);
                sink_hold = 400;
            end
            2: begin
                program_regs(32'($urandom) & 32'hFFFF_FFFE, $urandom, $urandom, $urandom);
                count = 60;
            end
            3: begin
                program_regs(32'd1, af, $urandom_range(4096, 0), af + $urandom_range(~af, 0));
                count = 200;
            end
            4: program_regs(32'd1, ADDR_FLOOR_RST, SIZE_FLOOR_RST, MEM_SIZE_RST);
            default: begin
                idle_on = 1'b0;
                af = $urandom_range(32'h0100_0000, 0);
                program_regs(32'd1, af, 32'd1, af + 32'h400);
            end
        endcase
        repeat (count) begin
            x = next_item();
            send_transfer(x.addr, x.len);
        end
    endtask

    initial begin : stimulus
        int p;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Out of reset the filter is off, whatever the transfer.
        send_transfer(32'd0, 32'd0);
        send_transfer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();
        write_reg(REG_ENABLE, 32'd1);
        cfg_valid <= 1'b0;

        // Reset floors and memory size; the end may land exactly on mem_size.
        send_transfer(32'h0007_FFFF, 32'h1000);
        send_transfer(32'h0008_0000, 32'h0FFF);
        send_transfer(32'h0008_0000, 32'h1000);
        send_transfer(32'h0008_0000, 32'h1000);
        send_transfer(32'h001F_F000, 32'h1000);
        send_transfer(32'h001F_F001, 32'h1000);
        send_transfer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_transfer(32'd0, 32'd0);

        // Widest window: the 33-bit end is what rejects the wrapping sum.
        program_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_transfer(32'd0, 32'd0);
        send_transfer(32'hFFFF_FFFF, 32'd0);
        send_transfer(32'hFFFF_FFFF, 32'd1);
        send_transfer(32'd1, 32'hFFFF_FFFE);
        send_transfer(32'd0, 32'd0);

        program_regs(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_transfer(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_transfer(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_transfer(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        program_regs(32'd1, 32'd0, 32'd0, 32'd0);
        send_transfer(32'd0, 32'd0);
        send_transfer(32'd0, 32'd1);

        // Only bit 0 of the enable register counts.
        program_regs(32'hFFFF_FFFE, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_transfer(32'h0008_0000, 32'h1000);

        for (p = 0; p < 6; p++) begin
            run_phase(p);
        end

        wait_idle();
        repeat (TABLE_DEPTH + 8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
            $display("transfer_window_dedup_filter verification clean");
        end else begin
            $display("transfer_window_dedup_filter verification failed");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/twdf_pkg.sv
rtl/twdf_pair_ram.sv
rtl/twdf_cfg_regs.sv
rtl/twdf_scan_ctrl.sv
rtl/transfer_window_dedup_filter.sv
dv/transfer_window_dedup_filter_test.sv
